/* hdl/btndb_pkg.sv */
// Shared types and constants for the three-key debounce / click / hold block.
// No dependencies; used by the key, event and top-level modules by scoped names.
`default_nettype none

package btndb_pkg;

  // Stable-level change seen by one key debouncer
  typedef enum logic [1:0] {
    EDGE_NO   = 2'd0,
    EDGE_DOWN = 2'd1,
    EDGE_UP   = 2'd2
  } key_edge_t;

  // Event codes carried on the result channel
  typedef enum logic [2:0] {
    EV_NONE         = 3'd0,
    EV_UP_CLICK     = 3'd1,
    EV_DOWN_CLICK   = 3'd2,
    EV_HOLD         = 3'd3,
    EV_ACTION_CLICK = 3'd4
  } event_t;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 8'd1;

  localparam int unsigned MS_W = 16;
  localparam logic [MS_W-1:0] DEBOUNCE_RST   = 16'd20;
  localparam logic [MS_W-1:0] LONG_PRESS_RST = 16'd600;

  localparam int unsigned NOW_W = 32;

  // Per-item control toward the key and event units
  typedef struct packed {
    logic first;  // first item after reset: capture only
    logic step;   // any later item: full update
  } item_ctl_t;

endpackage

`default_nettype wire

/* hdl/btndb_key.sv */
// One key debouncer: raw level, stable level and last raw change time.
// Depends on btndb_pkg.
`default_nettype none

module btndb_key #(
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire btndb_pkg::item_ctl_t        ctl,
  input  wire logic                        level,
  input  wire logic [TIME_BITS-1:0]        now,
  input  wire logic [btndb_pkg::MS_W-1:0]  settle_ms,
  output btndb_pkg::key_edge_t             key_edge,
  output logic                             stable
);

  localparam int unsigned CMP_W = (TIME_BITS > btndb_pkg::MS_W) ? TIME_BITS : btndb_pkg::MS_W;

  logic                 raw_r, raw_nxt;
  logic                 stable_r, stable_nxt;
  logic [TIME_BITS-1:0] chg_r, chg_nxt;
  logic [TIME_BITS-1:0] held;
  logic                 too_short;

  assign held      = now - chg_nxt;
  assign too_short = CMP_W'(held) < CMP_W'(settle_ms);

  always_comb begin
    raw_nxt    = level;
    chg_nxt    = (ctl.first || (level != raw_r)) ? now : chg_r;
    stable_nxt = stable_r;
    key_edge   = btndb_pkg::EDGE_NO;
    if (ctl.first) begin
      stable_nxt = level;
    end else if ((stable_r != level) && !too_short) begin
      stable_nxt = level;
      key_edge   = level ? btndb_pkg::EDGE_DOWN : btndb_pkg::EDGE_UP;
    end
  end

  // Post-update stable level, seen by the hold logic in the same item
  assign stable = stable_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_r    <= 1'b0;
      stable_r <= 1'b0;
      chg_r    <= '0;
    end else if (ctl.first || ctl.step) begin
      raw_r    <= raw_nxt;
      stable_r <= stable_nxt;
      chg_r    <= chg_nxt;
    end
  end

endmodule

`default_nettype wire

/* hdl/btndb_evt.sv */
// Event priority and action-key long-press tracking.
// Depends on btndb_pkg; fed by the three btndb_key debouncers.
`default_nettype none

module btndb_evt #(
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire btndb_pkg::item_ctl_t        ctl,
  input  wire logic [TIME_BITS-1:0]        now,
  input  wire logic [btndb_pkg::MS_W-1:0]  long_press_ms,
  input  wire logic                        action_level,
  input  wire btndb_pkg::key_edge_t        up_edge,
  input  wire btndb_pkg::key_edge_t        down_edge,
  input  wire btndb_pkg::key_edge_t        act_edge,
  input  wire logic                        act_stable,
  output btndb_pkg::event_t                event_res
);

  localparam int unsigned CMP_W = (TIME_BITS > btndb_pkg::MS_W) ? TIME_BITS : btndb_pkg::MS_W;

  logic [TIME_BITS-1:0] hold_start_r, hold_start_nxt;
  logic                 hold_emitted_r, hold_emitted_nxt;
  logic                 armed;
  logic [TIME_BITS-1:0] held;
  logic                 long_enough;

  assign armed       = (act_edge == btndb_pkg::EDGE_DOWN);
  assign held        = now - (armed ? now : hold_start_r);
  assign long_enough = CMP_W'(held) >= CMP_W'(long_press_ms);

  always_comb begin
    hold_start_nxt   = hold_start_r;
    hold_emitted_nxt = hold_emitted_r;
    event_res        = btndb_pkg::EV_NONE;
    if (ctl.first) begin
      hold_start_nxt   = now;
      hold_emitted_nxt = action_level;
    end else if (up_edge == btndb_pkg::EDGE_DOWN) begin
      event_res = btndb_pkg::EV_UP_CLICK;
    end else if (down_edge == btndb_pkg::EDGE_DOWN) begin
      event_res = btndb_pkg::EV_DOWN_CLICK;
    end else begin
      // re-arm the hold timer on a fresh action press
      if (armed) begin
        hold_start_nxt   = now;
        hold_emitted_nxt = 1'b0;
      end
      if (act_stable && !hold_emitted_nxt && long_enough) begin
        hold_emitted_nxt = 1'b1;
        event_res        = btndb_pkg::EV_HOLD;
      end else if ((act_edge == btndb_pkg::EDGE_UP) && !hold_emitted_nxt) begin
        event_res = btndb_pkg::EV_ACTION_CLICK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_start_r   <= '0;
      hold_emitted_r <= 1'b0;
    end else if (ctl.first || ctl.step) begin
      hold_start_r   <= hold_start_nxt;
      hold_emitted_r <= hold_emitted_nxt;
    end
  end

endmodule

`default_nettype wire

/* hdl/button_debounce_click_hold.sv */
// Top level: three-key debouncer with up/down clicks and action click/hold.
// Depends on btndb_pkg, btndb_key and btndb_evt.
//
//   channel  direction  handshake              payload
//   in_      slave      in_tvalid / in_tready   in_tdata[39:0]
//   out_     master     out_tvalid / out_tready out_tdata[7:0]
//   cfg_     slave      cfg_valid / cfg_ready   cfg_index[7:0], cfg_data[15:0]
//
// One item per cycle sustained while out_tready is high; results come from the result register.
// Work is done while an item moves from the input register to the result register.
// The first item after reset only loads key state and yields no result.
// A stalled result holds; the input register still takes one item meanwhile.
// Reset is synchronous, active low, and clears all key and hold state.
`default_nettype none

module button_debounce_click_hold #(
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [31:0] now_ms, [32] up_pressed, [33] down_pressed, [34] action_pressed, [39:35] zero
  input  wire logic [39:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [2:0] event_res, [7:3] zero
  output logic [7:0]       out_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [btndb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [btndb_pkg::MS_W-1:0]      cfg_data
);

  localparam int unsigned NKEY = 3;

  logic [btndb_pkg::MS_W-1:0] debounce_r;
  logic [btndb_pkg::MS_W-1:0] long_press_r;

  logic                          s1_valid_r;
  logic [btndb_pkg::NOW_W-1:0]   s1_now_r;
  logic [NKEY-1:0]               s1_lvl_r;
  logic                          started_r;
  logic                          out_valid_r;
  btndb_pkg::event_t             out_event_r;

  logic                          fire;
  btndb_pkg::item_ctl_t          ctl;
  logic [TIME_BITS-1:0]          now_t;
  btndb_pkg::key_edge_t          key_edge [NKEY];
  logic [NKEY-1:0]               key_stable;
  btndb_pkg::event_t             event_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r   <= btndb_pkg::DEBOUNCE_RST;
      long_press_r <= btndb_pkg::LONG_PRESS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        btndb_pkg::CFG_DEBOUNCE:   debounce_r   <= cfg_data;
        btndb_pkg::CFG_LONG_PRESS: long_press_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance the input register into the result register when the result slot frees
  assign fire      = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || fire;
  assign ctl       = {fire && !started_r, fire && started_r};

  generate
    if (TIME_BITS >= btndb_pkg::NOW_W) begin : g_ext
      assign now_t = {{(TIME_BITS - btndb_pkg::NOW_W){1'b0}}, s1_now_r};
    end else begin : g_trunc
      assign now_t = s1_now_r[TIME_BITS-1:0];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_now_r <= in_tdata[31:0];
      s1_lvl_r <= in_tdata[34:32];
    end
  end

  for (genvar k = 0; k < NKEY; k++) begin : g_key
    btndb_key #(.TIME_BITS(TIME_BITS)) u_key (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .level       (s1_lvl_r[k]),
      .now         (now_t),
      .settle_ms   (debounce_r),
      .key_edge    (key_edge[k]),
      .stable      (key_stable[k])
    );
  end

  btndb_evt #(.TIME_BITS(TIME_BITS)) u_evt (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .now           (now_t),
    .long_press_ms (long_press_r),
    .action_level  (s1_lvl_r[2]),
    .up_edge       (key_edge[0]),
    .down_edge     (key_edge[1]),
    .act_edge      (key_edge[2]),
    .act_stable    (key_stable[2]),
    .event_res     (event_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        s1_valid_r <= 1'b1;
      end else if (fire) begin
        s1_valid_r <= 1'b0;
      end
      if (fire) begin
        started_r   <= 1'b1;
        out_valid_r <= started_r;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      out_event_r <= event_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_event_r};

endmodule

`default_nettype wire

/* hdl/btndb_chk.sv */
// Port-level checker for button_debounce_click_hold, attached by bind.
// Depends only on the top level's ports.
`default_nettype none

module btndb_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [7:0]  out_tdata
);

  // A stalled result holds its item
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Reset empties the result slot
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // Reset empties the input register, so input is ready next cycle
  a_rst_in: assert property (@(posedge clk) !rst_n |=> in_tready)
    else $error("input not ready right after reset");

  // Only defined event codes leave the block
  a_evt_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[7:3] == 5'd0) && (out_tdata[2:0] <= 3'd4))
    else $error("undefined event code");

  // No result is valid right after reset is released
  a_first_none: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |=> !out_tvalid)
    else $error("result without a prior non-first item");

endmodule

bind button_debounce_click_hold btndb_chk u_btndb_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

/* tb/tb_button_debounce_click_hold.sv */
`timescale 1ns / 100ps
// Self-checking testbench for button_debounce_click_hold: drives timestamped key samples
// and timing register writes, predicts each click / hold event. Depends on btndb_pkg.

module tb_button_debounce_click_hold;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 4;

  // Debounce and click / hold prediction, plus the store of events still due
  class key_event_board;
    logic [btndb_pkg::MS_W-1:0] settle_ms;
    logic [btndb_pkg::MS_W-1:0] long_press_ms;
    bit                         started;
    bit [2:0]                   raw_lv;
    bit [2:0]                   stab_lv;
    logic [31:0]                raw_t [3];
    logic [31:0]                hold_t;
    bit                         hold_done;
    btndb_pkg::event_t          pending_events [$];
    int                         mismatches;

    function new();
      settle_ms     = btndb_pkg::DEBOUNCE_RST;
      long_press_ms = btndb_pkg::LONG_PRESS_RST;
      started       = 0;
      raw_lv        = '0;
      stab_lv       = '0;
      foreach (raw_t[k]) raw_t[k] = '0;
      hold_t        = '0;
      hold_done     = 0;
      mismatches    = 0;
    endfunction

    function void write_reg(logic [btndb_pkg::CFG_IDX_W-1:0] idx,
                            logic [btndb_pkg::MS_W-1:0] val);
      case (idx)
        btndb_pkg::CFG_DEBOUNCE:   settle_ms = val;
        btndb_pkg::CFG_LONG_PRESS: long_press_ms = val;
        default: ;
      endcase
    endfunction

    function btndb_pkg::key_edge_t step_key(int k, bit lv, logic [31:0] now);
      logic [31:0] dt;
      if (lv != raw_lv[k]) begin
        raw_lv[k] = lv;
        raw_t[k]  = now;
      end
      dt = now - raw_t[k];
      if (stab_lv[k] == raw_lv[k]) return btndb_pkg::EDGE_NO;
      if (dt < {16'd0, settle_ms}) return btndb_pkg::EDGE_NO;
      stab_lv[k] = raw_lv[k];
      return stab_lv[k] ? btndb_pkg::EDGE_DOWN : btndb_pkg::EDGE_UP;
    endfunction

    function void note_item(logic [39:0] d);
      logic [31:0]           now;
      logic [31:0]           held;
      logic [2:0]            lv;
      btndb_pkg::key_edge_t  e_up, e_dn, e_act;
      btndb_pkg::event_t     ev;
      now = d[31:0];
      lv  = d[34:32];
      if (!started) begin
        // first sample only captures the key levels
        raw_lv    = lv;
        stab_lv   = lv;
        foreach (raw_t[k]) raw_t[k] = now;
        hold_t    = now;
        hold_done = lv[2];
        started   = 1;
        return;
      end
      e_up  = step_key(0, lv[0], now);
      e_dn  = step_key(1, lv[1], now);
      e_act = step_key(2, lv[2], now);
      if (e_up == btndb_pkg::EDGE_DOWN) begin
        ev = btndb_pkg::EV_UP_CLICK;
      end else if (e_dn == btndb_pkg::EDGE_DOWN) begin
        ev = btndb_pkg::EV_DOWN_CLICK;
      end else begin
        if (e_act == btndb_pkg::EDGE_DOWN) begin
          hold_t    = now;
          hold_done = 0;
        end
        held = now - hold_t;
        if (stab_lv[2] && !hold_done && held >= {16'd0, long_press_ms}) begin
          hold_done = 1;
          ev = btndb_pkg::EV_HOLD;
        end else if (e_act == btndb_pkg::EDGE_UP && !hold_done) begin
          ev = btndb_pkg::EV_ACTION_CLICK;
        end else begin
          ev = btndb_pkg::EV_NONE;
        end
      end
      pending_events.push_back(ev);
    endfunction

    task report_mismatch(string msg);
      $display("%0t: mismatch: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_result(logic [7:0] d);
      btndb_pkg::event_t want;
      if (pending_events.size() == 0) begin
        report_mismatch($sformatf("event %0d with no item pending", d[2:0]));
        return;
      end
      want = pending_events.pop_front();
      if (d[2:0] != want)
        report_mismatch($sformatf("event_res %0d, expected %0d (%s)", d[2:0], want,
                                  want.name()));
      if (d[7:3] != '0)
        report_mismatch($sformatf("out_tdata padding 0x%0h", d[7:3]));
    endtask

    function int pending();
      return pending_events.size();
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [39:0]                     in_tdata = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b1;
  logic [7:0]                      out_tdata;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [btndb_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [btndb_pkg::MS_W-1:0]      cfg_data = '0;

  key_event_board board = new();
  int unsigned    cycles = 0;
  int unsigned    ready_hold = 0;
  bit             quiet_in = 0;
  logic [31:0]    cur_t = '0;
  logic [2:0]     keys = '0;

  button_debounce_click_hold i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [31:0] now_ms, [32] up, [33] down, [34] action, [39:35] zero
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [2:0] event_res, [7:3] zero
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Result side: alternate ready runs and stalls, mostly short, some long
  always @(posedge clk) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      out_tready <= ~out_tready;
      if (out_tready)
        ready_hold <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(5, 40);
      else
        ready_hold <= ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(0, 6);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata);
  end

  task automatic send_sample(input logic [39:0] d);
    int unsigned gap;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet_in || r < 60) gap = 0;
    else if (r < 90) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 40);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
    board.note_item(d);
  endtask

  // Drop the input and wait until every expected result has left
  task automatic wait_events_drained();
    in_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  // Write an unused index with junk, then both timing registers
  task automatic write_timing(input logic [btndb_pkg::MS_W-1:0] deb,
                              input logic [btndb_pkg::MS_W-1:0] lng);
    logic [btndb_pkg::CFG_IDX_W-1:0] idx [3];
    logic [btndb_pkg::MS_W-1:0]      val [3];
    logic [31:0]                     rnd;
    rnd    = $urandom_range(2, 255);
    idx[0] = rnd[btndb_pkg::CFG_IDX_W-1:0];
    rnd    = $urandom;
    val[0] = rnd[btndb_pkg::MS_W-1:0];
    idx[1] = btndb_pkg::CFG_DEBOUNCE;
    val[1] = deb;
    idx[2] = btndb_pkg::CFG_LONG_PRESS;
    val[2] = lng;
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      do @(posedge clk); while (!cfg_ready);
      board.write_reg(idx[i], val[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic run_directed();
    logic [31:0] dir_t [25] = '{
      32'hFFFF_FFF0, 32'hFFFF_FFF8, 32'h0000_000B, 32'h0000_000C, 32'h0000_0010,
      32'h0000_0024, 32'h0000_0300, 32'h0000_0310, 32'h0000_0330, 32'h0000_0400,
      32'h0000_0414, 32'h0000_066B, 32'h0000_066C, 32'h0000_0700, 32'h0000_0714,
      32'h0000_0800, 32'h0000_0814, 32'h0000_0820, 32'h0000_0834, 32'h0000_0900,
      32'h0000_0914, 32'h0000_0920, 32'h0000_0925, 32'hFFFF_FFFF, 32'h0000_0000};
    // {action, down, up}
    logic [2:0] dir_k [25] = '{
      3'b100, 3'b000, 3'b000, 3'b000, 3'b111,
      3'b111, 3'b111, 3'b000, 3'b000, 3'b100,
      3'b100, 3'b100, 3'b100, 3'b000, 3'b000,
      3'b100, 3'b100, 3'b000, 3'b000, 3'b010,
      3'b010, 3'b000, 3'b010, 3'b101, 3'b101};
    for (int i = 0; i < 25; i++) send_sample({5'd0, dir_k[i], dir_t[i]});
    cur_t = dir_t[24];
    keys  = dir_k[24];
  endtask

  task automatic run_key_phase(input int unsigned deb, input int unsigned lng,
                               input int unsigned n, input logic [31:0] t0);
    int unsigned r;
    int unsigned step;
    int unsigned nz;
    logic [2:0]  lvl;
    logic [39:0] d;
    // registers change only with the block idle
    wait_events_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_timing(deb[15:0], lng[15:0]);
    cur_t = t0;
    for (int i = 0; i < n; i++) begin
      if (i % 64 == 0) quiet_in = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 3) begin
        // noise: arbitrary timestamp and levels
        nz    = $urandom_range(0, 7);
        lvl   = nz[2:0];
        cur_t = $urandom;
        keys  = lvl;
      end else begin
        if (r < 55) step = $urandom_range(0, deb / 2 + 1);
        else if (r < 85) step = $urandom_range(deb / 2, deb + lng / 8 + 1);
        else step = $urandom_range(0, lng + deb + 1);
        cur_t = cur_t + step;
        for (int k = 0; k < 3; k++)
          if ($urandom_range(0, 99) < ((k == 2) ? 4 : 6)) keys[k] = ~keys[k];
        lvl = keys;
        // single-sample bounce on one key
        if ($urandom_range(0, 99) < 5) lvl[$urandom_range(0, 2)] ^= 1'b1;
      end
      d = {5'd0, lvl, cur_t};
      send_sample(d);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    run_key_phase(0, 0, 165, $urandom);
    run_key_phase(65535, 65535, 165, 32'hFFFF_FF00);
    run_key_phase(5, 40, 165, $urandom);
    run_key_phase(1, 3, 165, $urandom);
    run_key_phase(20, 600, 165, $urandom);
    run_key_phase(0, 65535, 165, $urandom);
    run_key_phase(65535, 0, 150, $urandom);
    run_key_phase($urandom_range(0, 200), $urandom_range(0, 2000), 230, $urandom);
    wait_events_drained();
    repeat (20) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/btndb_pkg.sv
hdl/btndb_key.sv
hdl/btndb_evt.sv
hdl/button_debounce_click_hold.sv
hdl/btndb_chk.sv
tb/tb_button_debounce_click_hold.sv
